>>> sv/gcpl_pkg.sv
package gcpl_pkg;

  localparam int MAX_GLYPHS   = 1024;
  localparam int DIRECT_CODES = 128;

  localparam int CODE_W = 21;
  localparam int SLOT_W = $clog2(MAX_GLYPHS);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int DIR_W  = (DIRECT_CODES > 1) ? $clog2(DIRECT_CODES) : 1;
  localparam int OP_W   = 2;
  localparam int CFG_W  = 1;

  localparam logic [CODE_W-1:0] SUB_CODE_RESET = CODE_W'(42);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [CFG_W-1:0] {
    CFG_SUB_ENABLE = 1'b0,
    CFG_SUB_CODE   = 1'b1
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_DCMP  = 5'b00100,
    S_READ  = 5'b01000,
    S_CMP   = 5'b10000
  } state_t;

endpackage

>>> sv/gcpl_ram.sv
module gcpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/glyph_code_point_lookup_core.sv
// glyph code point lookup: a request is taken when start is high and busy is
// low; each request gives exactly one result, shown for one cycle with done
// high, and the receiver cannot stall it. clear and append requests answer on
// the cycle after they are taken and leave busy low, so they may follow each
// other every cycle. a lookup of a code below 128 reads the direct map and
// goes through a start state and then a direct-map compare state. any other
// code runs a binary search over the n loaded entries through the single
// read port of the code table: each halving step is a read state and then a
// compare state, and an empty table misses in the start state. a miss that
// retries with the substitute code adds the cost of the second lookup. busy
// stays high for the whole lookup. reset and clear empty the direct map at
// once through its valid bits, so there is no clearing pass. configuration
// writes belong in idle periods only, since a running lookup reads the
// registers.
module glyph_code_point_lookup_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [gcpl_pkg::OP_W-1:0]      op,
  input  logic [gcpl_pkg::CODE_W-1:0]    code_point,
  output logic                           done,
  output logic                           found,
  output logic [gcpl_pkg::SLOT_W-1:0]    glyph_index,
  output logic                           table_full,
  output logic                           order_error,
  input  logic                           cfg_write,
  input  logic [gcpl_pkg::CFG_W-1:0]     cfg_index,
  input  logic [gcpl_pkg::CODE_W-1:0]    cfg_data
);

  import gcpl_pkg::*;

  // configuration
  logic              sub_enable;
  logic [CODE_W-1:0] sub_code;

  // table state
  logic [CNT_W-1:0]        entry_count;
  logic                    prefix_below;
  logic [CODE_W-1:0]       previous_code;
  logic [DIRECT_CODES-1:0] dvalid;

  // lookup sequencer
  state_t            state;
  logic [CODE_W-1:0] lookup_code;  // code as requested
  logic [CODE_W-1:0] key;          // code being searched now
  logic              retried;
  logic [SLOT_W-1:0] base;
  logic [CNT_W-1:0]  len;
  logic [SLOT_W-1:0] half;

  // memories
  logic              code_we;
  logic [SLOT_W-1:0] code_raddr;
  logic [CODE_W-1:0] code_rdata;
  logic              dmap_we;
  logic [DIR_W-1:0]  key_idx;
  logic [SLOT_W-1:0] dmap_rdata;

  logic              accept;
  logic              app_full;
  logic              app_order;
  logic              app_ok;
  logic              key_direct;
  logic              lk_hit;
  logic              lk_miss;
  logic [SLOT_W-1:0] lk_slot;
  logic              retry;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;

  // append checks, evaluated on the request itself
  assign app_full  = (entry_count >= CNT_W'(MAX_GLYPHS));
  assign app_order = (entry_count != '0) && (code_point <= previous_code);
  assign app_ok    = accept && (op == OP_APPEND) && !app_full && !app_order;

  assign code_we = app_ok;
  assign dmap_we = app_ok && prefix_below && (code_point < CODE_W'(DIRECT_CODES));

  // the shared probe: len >> 1 steps past base, or base itself once len is one
  assign half       = SLOT_W'(len >> 1);
  assign code_raddr = base + half;

  assign key_direct = (key < CODE_W'(DIRECT_CODES));
  assign key_idx    = key[DIR_W-1:0];

  gcpl_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_GLYPHS)
  ) u_code_table (
    .clk   (clk),
    .we    (code_we),
    .waddr (entry_count[SLOT_W-1:0]),
    .wdata (code_point),
    .raddr (code_raddr),
    .rdata (code_rdata)
  );

  gcpl_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DIRECT_CODES)
  ) u_direct_map (
    .clk   (clk),
    .we    (dmap_we),
    .waddr (code_point[DIR_W-1:0]),
    .wdata (entry_count[SLOT_W-1:0]),
    .raddr (key_idx),
    .rdata (dmap_rdata)
  );

  // hit or miss decided by the current step
  always_comb begin
    lk_hit  = 1'b0;
    lk_miss = 1'b0;
    lk_slot = '0;
    case (state)
      S_START: begin
        if (!key_direct && entry_count == '0) begin
          lk_miss = 1'b1;
        end
      end
      S_DCMP: begin
        if (dvalid[key_idx]) begin
          lk_hit  = 1'b1;
          lk_slot = dmap_rdata;
        end else begin
          lk_miss = 1'b1;
        end
      end
      S_CMP: begin
        // last probe reads base itself
        if (len == CNT_W'(1)) begin
          if (code_rdata == key) begin
            lk_hit  = 1'b1;
            lk_slot = base;
          end else begin
            lk_miss = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // one second try with the substitute code
  assign retry = lk_miss && !retried && sub_enable && (lookup_code != sub_code);

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_enable    <= 1'b1;
      sub_code      <= SUB_CODE_RESET;
      entry_count   <= '0;
      prefix_below  <= 1'b1;
      previous_code <= '0;
      dvalid        <= '0;
      state         <= S_IDLE;
      retried       <= 1'b0;
      done          <= 1'b0;
      found         <= 1'b0;
      glyph_index   <= '0;
      table_full    <= 1'b0;
      order_error   <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_write) begin
        case (cfg_index)
          CFG_SUB_ENABLE: sub_enable <= cfg_data[0];
          CFG_SUB_CODE:   sub_code   <= cfg_data;
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (op)
              OP_CLEAR: begin
                entry_count   <= '0;
                prefix_below  <= 1'b1;
                previous_code <= '0;
                dvalid        <= '0;
                done          <= 1'b1;
                found         <= 1'b0;
                glyph_index   <= '0;
                table_full    <= 1'b0;
                order_error   <= 1'b0;
              end
              OP_APPEND: begin
                if (app_ok) begin
                  if (dmap_we) begin
                    dvalid[code_point[DIR_W-1:0]] <= 1'b1;
                  end else begin
                    prefix_below <= 1'b0;
                  end
                  previous_code <= code_point;
                  entry_count   <= entry_count + CNT_W'(1);
                end
                done        <= 1'b1;
                found       <= 1'b0;
                glyph_index <= '0;
                table_full  <= app_full;
                order_error <= app_order;
              end
              OP_LOOKUP: begin
                lookup_code <= code_point;
                key         <= code_point;
                retried     <= 1'b0;
                state       <= S_START;
              end
              default: begin
                // unused op: no state change, empty result
                done        <= 1'b1;
                found       <= 1'b0;
                glyph_index <= '0;
                table_full  <= 1'b0;
                order_error <= 1'b0;
              end
            endcase
          end
        end
        S_START: begin
          if (key_direct) begin
            state <= S_DCMP;
          end else begin
            base  <= '0;
            len   <= entry_count;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (len != CNT_W'(1)) begin
            if (code_rdata <= key) begin
              base <= base + half;
            end
            len   <= len - CNT_W'(half);
            state <= S_READ;
          end
        end
        default: begin
        end
      endcase

      // finish or retry, overrides the step above
      if (lk_hit) begin
        done        <= 1'b1;
        found       <= 1'b1;
        glyph_index <= lk_slot;
        table_full  <= 1'b0;
        order_error <= 1'b0;
        state       <= S_IDLE;
      end else if (retry) begin
        key     <= sub_code;
        retried <= 1'b1;
        state   <= S_START;
      end else if (lk_miss) begin
        done        <= 1'b1;
        found       <= 1'b0;
        glyph_index <= '0;
        table_full  <= 1'b0;
        order_error <= 1'b0;
        state       <= S_IDLE;
      end
    end
  end

  // a result never shows while a lookup is still running
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // a found slot always lies inside the loaded part of the table
  a_found_loaded: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (CNT_W'(glyph_index) < entry_count))
    else $error("found slot beyond entry count");

  // a miss reports slot zero, and append flags never come with a hit
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (!found || table_full || order_error)) |-> (glyph_index == '0 && !found)
      || (done && found && !table_full && !order_error))
    else $error("inconsistent result fields");

  // a taken request either answers next cycle or starts a lookup
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("request taken without progress");

endmodule
